@@ hw/rtl/tmmb_pkg.sv @@
// ---------------------------------------------------------------------------
// TRS model matrix builder package
// Shared constants, types and fixed-point helpers.
// ---------------------------------------------------------------------------
package tmmb_pkg;

   localparam int ANGLE_W      = 16;
   localparam int ANGLE_BITS   = 16;
   localparam int CORDIC_STEPS = 30;
   localparam int CW           = 33;   // CORDIC and quaternion word, Q30 plus guard

   localparam logic signed [CW-1:0] CORDIC_GAIN  = 33'sd652032874;
   localparam logic signed [CW-1:0] QUARTER_TURN = 33'sd1073741824;
   localparam logic signed [34:0]   Q30_ONE      = 35'sd1073741824;

   typedef logic signed [31:0] word_type;
   typedef logic signed [CW-1:0] q30_type;
   typedef logic signed [34:0] rot_type;
   typedef logic signed [36:0] prod_type;

   typedef struct packed {
      word_type [2:0] pos;
      word_type [2:0] scl;
   } xform_type;

   typedef struct packed {
      q30_type [2:0] cos_v;
      q30_type [2:0] sin_v;
   } sincos_type;

   function automatic q30_type atan_turn(input logic [4:0] i);
      q30_type r;
      case (i)
         5'd0:  r = 33'sd536870912;
         5'd1:  r = 33'sd316933406;
         5'd2:  r = 33'sd167458907;
         5'd3:  r = 33'sd85004756;
         5'd4:  r = 33'sd42667331;
         5'd5:  r = 33'sd21354465;
         5'd6:  r = 33'sd10679838;
         5'd7:  r = 33'sd5340245;
         5'd8:  r = 33'sd2670163;
         5'd9:  r = 33'sd1335087;
         5'd10: r = 33'sd667544;
         5'd11: r = 33'sd333772;
         5'd12: r = 33'sd166886;
         5'd13: r = 33'sd83443;
         5'd14: r = 33'sd41722;
         5'd15: r = 33'sd20861;
         5'd16: r = 33'sd10430;
         5'd17: r = 33'sd5215;
         5'd18: r = 33'sd2608;
         5'd19: r = 33'sd1304;
         5'd20: r = 33'sd652;
         5'd21: r = 33'sd326;
         5'd22: r = 33'sd163;
         5'd23: r = 33'sd81;
         5'd24: r = 33'sd41;
         5'd25: r = 33'sd20;
         5'd26: r = 33'sd10;
         5'd27: r = 33'sd5;
         5'd28: r = 33'sd3;
         5'd29: r = 33'sd1;
         default: r = '0;
      endcase
      return r;
   endfunction

   // Q30 product, rounded half up
   function automatic q30_type mul_q30(input q30_type a, input q30_type b);
      logic signed [2*CW-1:0] p;
      p = a * b;
      p = p + 66'sd536870912;
      return q30_type'(p >>> 30);
   endfunction

   function automatic prod_type mul_rs(input rot_type a, input word_type b);
      logic signed [66:0] p;
      p = a * b;
      p = p + 67'sd536870912;
      return prod_type'(p >>> 30);
   endfunction

   function automatic word_type sat32(input prod_type v);
      word_type r;
      if (v > 37'sd2147483647)
         r = 32'sh7FFFFFFF;
      else if (v < -37'sd2147483648)
         r = 32'sh80000000;
      else
         r = v[31:0];
      return r;
   endfunction

endpackage

@@ hw/rtl/tmmb_cordic.sv @@
// ---------------------------------------------------------------------------
// Half-angle sine/cosine pipeline
// Three-lane rotation-mode CORDIC, one step per stage, side data carried along.
// ---------------------------------------------------------------------------
module tmmb_cordic import tmmb_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      adv,
   input  logic                      in_valid,
   input  logic [2:0][ANGLE_W-1:0]   in_angle,
   input  xform_type                 in_side,
   output logic                      out_valid,
   output sincos_type                out_sc,
   output xform_type                 out_side
);

   localparam logic [CW-1:0] AMASK = CW'((CW'(1) << ANGLE_BITS) - CW'(1));

   q30_type   x_ff  [0:CORDIC_STEPS][0:2];
   q30_type   y_ff  [0:CORDIC_STEPS][0:2];
   q30_type   z_ff  [0:CORDIC_STEPS][0:2];
   logic      up_ff [0:CORDIC_STEPS][0:2];
   xform_type side_ff [0:CORDIC_STEPS];
   logic      vld_ff  [0:CORDIC_STEPS];

   q30_type   h_in  [0:2];

   always_comb begin
      for (int l = 0; l < 3; l++)
         h_in[l] = $signed((CW'(in_angle[l]) & AMASK) << (31 - ANGLE_BITS));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int l = 0; l < 3; l++) begin
            x_ff[0][l]  <= CORDIC_GAIN;
            y_ff[0][l]  <= '0;
            up_ff[0][l] <= (h_in[l] >= QUARTER_TURN);
            z_ff[0][l]  <= (h_in[l] >= QUARTER_TURN) ? h_in[l] - QUARTER_TURN : h_in[l];
         end
         side_ff[0] <= in_side;
         for (int i = 0; i < CORDIC_STEPS; i++) begin
            for (int l = 0; l < 3; l++) begin
               if (!z_ff[i][l][CW-1]) begin
                  x_ff[i+1][l] <= x_ff[i][l] - (y_ff[i][l] >>> i);
                  y_ff[i+1][l] <= y_ff[i][l] + (x_ff[i][l] >>> i);
                  z_ff[i+1][l] <= z_ff[i][l] - atan_turn(5'(i));
               end else begin
                  x_ff[i+1][l] <= x_ff[i][l] + (y_ff[i][l] >>> i);
                  y_ff[i+1][l] <= y_ff[i][l] - (x_ff[i][l] >>> i);
                  z_ff[i+1][l] <= z_ff[i][l] + atan_turn(5'(i));
               end
               up_ff[i+1][l] <= up_ff[i][l];
            end
            side_ff[i+1] <= side_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= CORDIC_STEPS; i++)
            vld_ff[i] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= in_valid;
         for (int i = 0; i < CORDIC_STEPS; i++)
            vld_ff[i+1] <= vld_ff[i];
      end
   end

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         if (up_ff[CORDIC_STEPS][l]) begin
            out_sc.cos_v[l] = -y_ff[CORDIC_STEPS][l];
            out_sc.sin_v[l] = x_ff[CORDIC_STEPS][l];
         end else begin
            out_sc.cos_v[l] = x_ff[CORDIC_STEPS][l];
            out_sc.sin_v[l] = y_ff[CORDIC_STEPS][l];
         end
      end
   end

   assign out_valid = vld_ff[CORDIC_STEPS];
   assign out_side  = side_ff[CORDIC_STEPS];

endmodule

@@ hw/rtl/trs_model_matrix_builder.sv @@
// ---------------------------------------------------------------------------
// TRS model matrix builder
// Euler angles to quaternion to rotation, composed with translate and scale;
// emits matrix rows 0 to 2, one per response.
// ---------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/stall    | three angles, position, scale
//  rsp     | out       | rsp_valid/stall    | row index, four columns, last flag
//
//  Pipeline: 31 CORDIC stages plus 5 arithmetic stages to the row buffer.
//  The single-row response port sets the request rate: three rows per request.
//  Reset clears all valid bits and the row counter; row data is not cleared.
//  A stalled response holds the row buffer; the pipeline stops only while
//  stage E holds a request, so bubbles ahead of it still close up.
// ---------------------------------------------------------------------------
module trs_model_matrix_builder import tmmb_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [15:0]       req_yaw_angle,
   input  logic [15:0]       req_pitch_angle,
   input  logic [15:0]       req_roll_angle,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic signed [31:0] req_scale_x,
   input  logic signed [31:0] req_scale_y,
   input  logic signed [31:0] req_scale_z,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_row_index,
   output logic signed [31:0] rsp_col0,
   output logic signed [31:0] rsp_col1,
   output logic signed [31:0] rsp_col2,
   output logic signed [31:0] rsp_col3,
   output logic              rsp_last_row
);

   logic        adv;
   logic        ser_ready;
   logic        c_valid;
   sincos_type  c_sc;
   xform_type   c_side;
   xform_type   in_side;

   logic [4:0]  vld_ff;          // stages A..E
   q30_type     cpcy_ff, spsy_ff, spcy_ff, cpsy_ff, cr_ff, sr_ff;
   q30_type     w_ff, x_ff, y_ff, z_ff;
   q30_type     xx_ff, yy_ff, zz_ff, xy_ff, xz_ff, yz_ff, wx_ff, wy_ff, wz_ff;
   rot_type     rot_ff [0:2][0:2];
   prod_type    ent_ff [0:2][0:2];
   xform_type   sa_ff, sb_ff, sc_ff, sd_ff, se_ff;

   word_type    hold_ff [0:2][0:2];
   word_type    hpos_ff [0:2];
   logic        hvld_ff;
   logic [1:0]  row_ff;

   assign in_side.pos = {req_pos_z, req_pos_y, req_pos_x};
   assign in_side.scl = {req_scale_z, req_scale_y, req_scale_x};

   assign ser_ready = !hvld_ff || (!rsp_stall && row_ff == 2'd2);
   assign adv       = !vld_ff[4] || ser_ready;
   assign req_stall = !adv;

   tmmb_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .in_angle  ({req_roll_angle, req_pitch_angle, req_yaw_angle}),
      .in_side   (in_side),
      .out_valid (c_valid),
      .out_sc    (c_sc),
      .out_side  (c_side)
   );

   always_ff @(posedge clock) begin
      if (reset)
         vld_ff <= '0;
      else if (adv)
         vld_ff <= {vld_ff[3:0], c_valid};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         // A: pitch/yaw cross terms
         cpcy_ff <= mul_q30(c_sc.cos_v[1], c_sc.cos_v[0]);
         spsy_ff <= mul_q30(c_sc.sin_v[1], c_sc.sin_v[0]);
         spcy_ff <= mul_q30(c_sc.sin_v[1], c_sc.cos_v[0]);
         cpsy_ff <= mul_q30(c_sc.cos_v[1], c_sc.sin_v[0]);
         cr_ff   <= c_sc.cos_v[2];
         sr_ff   <= c_sc.sin_v[2];
         sa_ff   <= c_side;
         // B: quaternion
         w_ff  <= mul_q30(cr_ff, cpcy_ff) + mul_q30(sr_ff, spsy_ff);
         x_ff  <= mul_q30(sr_ff, cpcy_ff) - mul_q30(cr_ff, spsy_ff);
         y_ff  <= mul_q30(cr_ff, spcy_ff) + mul_q30(sr_ff, cpsy_ff);
         z_ff  <= mul_q30(cr_ff, cpsy_ff) - mul_q30(sr_ff, spcy_ff);
         sb_ff <= sa_ff;
         // C: quaternion products
         xx_ff <= mul_q30(x_ff, x_ff);
         yy_ff <= mul_q30(y_ff, y_ff);
         zz_ff <= mul_q30(z_ff, z_ff);
         xy_ff <= mul_q30(x_ff, y_ff);
         xz_ff <= mul_q30(x_ff, z_ff);
         yz_ff <= mul_q30(y_ff, z_ff);
         wx_ff <= mul_q30(w_ff, x_ff);
         wy_ff <= mul_q30(w_ff, y_ff);
         wz_ff <= mul_q30(w_ff, z_ff);
         sc_ff <= sb_ff;
         // D: rotation matrix
         rot_ff[0][0] <= Q30_ONE - 35'(2 * (rot_type'(yy_ff) + rot_type'(zz_ff)));
         rot_ff[0][1] <= 35'(2 * (rot_type'(xy_ff) - rot_type'(wz_ff)));
         rot_ff[0][2] <= 35'(2 * (rot_type'(xz_ff) + rot_type'(wy_ff)));
         rot_ff[1][0] <= 35'(2 * (rot_type'(xy_ff) + rot_type'(wz_ff)));
         rot_ff[1][1] <= Q30_ONE - 35'(2 * (rot_type'(xx_ff) + rot_type'(zz_ff)));
         rot_ff[1][2] <= 35'(2 * (rot_type'(yz_ff) - rot_type'(wx_ff)));
         rot_ff[2][0] <= 35'(2 * (rot_type'(xz_ff) - rot_type'(wy_ff)));
         rot_ff[2][1] <= 35'(2 * (rot_type'(yz_ff) + rot_type'(wx_ff)));
         rot_ff[2][2] <= Q30_ONE - 35'(2 * (rot_type'(xx_ff) + rot_type'(yy_ff)));
         sd_ff <= sc_ff;
         // E: scale columns
         for (int r = 0; r < 3; r++)
            for (int k = 0; k < 3; k++)
               ent_ff[r][k] <= mul_rs(rot_ff[r][k], sd_ff.scl[k]);
         se_ff <= sd_ff;
      end
   end

   // row buffer, saturation on load
   always_ff @(posedge clock) begin
      if (vld_ff[4] && ser_ready) begin
         for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++)
               hold_ff[r][k] <= sat32(ent_ff[r][k]);
            hpos_ff[r] <= se_ff.pos[r];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hvld_ff <= 1'b0;
         row_ff  <= 2'd0;
      end else begin
         if (ser_ready)
            hvld_ff <= vld_ff[4];
         if (hvld_ff && !rsp_stall)
            row_ff <= (row_ff == 2'd2) ? 2'd0 : row_ff + 2'd1;
      end
   end

   always_comb begin
      case (row_ff)
         2'd0: begin
            rsp_col0 = hold_ff[0][0]; rsp_col1 = hold_ff[0][1];
            rsp_col2 = hold_ff[0][2]; rsp_col3 = hpos_ff[0];
         end
         2'd1: begin
            rsp_col0 = hold_ff[1][0]; rsp_col1 = hold_ff[1][1];
            rsp_col2 = hold_ff[1][2]; rsp_col3 = hpos_ff[1];
         end
         default: begin
            rsp_col0 = hold_ff[2][0]; rsp_col1 = hold_ff[2][1];
            rsp_col2 = hold_ff[2][2]; rsp_col3 = hpos_ff[2];
         end
      endcase
   end

   assign rsp_valid     = hvld_ff;
   assign rsp_row_index = row_ff;
   assign rsp_last_row  = (row_ff == 2'd2);

   a_row_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_row_index != 2'd3)
      else $error("row index out of range");

   a_row_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_row_index != 2'd2) |=>
         (rsp_valid && rsp_row_index == $past(rsp_row_index) + 2'd1))
      else $error("row sequence broken");

   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("request stalled with idle output");

endmodule

@@ test/trs_model_matrix_builder_tb.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// TRS model matrix builder testbench
// Drives object requests (angles, position, scale) in random bursts, predicts
// the three model-matrix rows of each request and checks every response row.
// ---------------------------------------------------------------------------
module trs_model_matrix_builder_tb;
   import tmmb_pkg::*;

   typedef struct {
      logic [15:0] yaw, pitch, roll;
      logic signed [31:0] pos [3];
      logic signed [31:0] scl [3];
   } object_type;

   typedef struct {
      logic [1:0] row;
      logic signed [31:0] c0, c1, c2, c3;
      logic last;
   } row_type;

   localparam longint GAIN = 652032874;
   localparam longint ONE_Q30 = 1073741824;
   localparam int IDLE_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [15:0] req_yaw_angle = '0, req_pitch_angle = '0, req_roll_angle = '0;
   logic signed [31:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic signed [31:0] req_scale_x = '0, req_scale_y = '0, req_scale_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_row_index;
   logic signed [31:0] rsp_col0, rsp_col1, rsp_col2, rsp_col3;
   logic rsp_last_row;

   object_type pending_objects[$];
   row_type expected_rows[$];
   int errors = 0;
   bit stimulus_done = 0;
   int idle_cycles = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   trs_model_matrix_builder u_top (.*);

   longint atan_tab [30] = '{536870912, 316933406, 167458907, 85004756, 42667331,
      21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
      41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1};

   function automatic longint qmul(longint a, longint b);
      return (a * b + (64'sd1 <<< 29)) >>> 30;
   endfunction

   task automatic half_angle_sincos(input logic [15:0] ang, output longint c,
                                    output longint s);
      longint h, z, x, y, dx, dy;
      bit upper;
      h = longint'(ang) << 15;
      upper = h >= ONE_Q30;
      z = upper ? h - ONE_Q30 : h;
      x = GAIN;
      y = 0;
      for (int i = 0; i < 30; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= atan_tab[i];
         end else begin
            x += dx; y -= dy; z += atan_tab[i];
         end
      end
      if (upper) begin
         c = -y; s = x;
      end else begin
         c = x; s = y;
      end
   endtask

   function automatic logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   task automatic predict_rows(input object_type o);
      longint cy, sy, cp, sp, cr, sr, cpcy, spsy, spcy, cpsy, w, x, y, z;
      longint xx, yy, zz, xy, xz, yz, wx, wy, wz;
      longint rm [3][3];
      row_type r;
      half_angle_sincos(o.yaw, cy, sy);
      half_angle_sincos(o.pitch, cp, sp);
      half_angle_sincos(o.roll, cr, sr);
      cpcy = qmul(cp, cy); spsy = qmul(sp, sy);
      spcy = qmul(sp, cy); cpsy = qmul(cp, sy);
      w = qmul(cr, cpcy) + qmul(sr, spsy);
      x = qmul(sr, cpcy) - qmul(cr, spsy);
      y = qmul(cr, spcy) + qmul(sr, cpsy);
      z = qmul(cr, cpsy) - qmul(sr, spcy);
      xx = qmul(x, x); yy = qmul(y, y); zz = qmul(z, z);
      xy = qmul(x, y); xz = qmul(x, z); yz = qmul(y, z);
      wx = qmul(w, x); wy = qmul(w, y); wz = qmul(w, z);
      rm[0][0] = ONE_Q30 - 2 * (yy + zz);
      rm[0][1] = 2 * (xy - wz);
      rm[0][2] = 2 * (xz + wy);
      rm[1][0] = 2 * (xy + wz);
      rm[1][1] = ONE_Q30 - 2 * (xx + zz);
      rm[1][2] = 2 * (yz - wx);
      rm[2][0] = 2 * (xz - wy);
      rm[2][1] = 2 * (yz + wx);
      rm[2][2] = ONE_Q30 - 2 * (xx + yy);
      for (int i = 0; i < 3; i++) begin
         r.row = 2'(i);
         r.c0 = clamp32(qmul(rm[i][0], longint'(o.scl[0])));
         r.c1 = clamp32(qmul(rm[i][1], longint'(o.scl[1])));
         r.c2 = clamp32(qmul(rm[i][2], longint'(o.scl[2])));
         r.c3 = o.pos[i];
         r.last = (i == 2);
         expected_rows.push_back(r);
      end
   endtask

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 5))
         0: return 32'h7FFFFFFF;
         1: return 32'h80000000;
         2: return 32'(int'($urandom_range(0, 262144)) - 131072);
         default: return $urandom();
      endcase
   endfunction

   function automatic object_type make_object(logic [15:0] a, logic [15:0] b,
                                              logic [15:0] c, logic [31:0] p,
                                              logic [31:0] s);
      object_type o;
      o.yaw = a; o.pitch = b; o.roll = c;
      for (int i = 0; i < 3; i++) begin
         o.pos[i] = p;
         o.scl[i] = s;
      end
      return o;
   endfunction

   initial begin
      object_type o;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      // directed: zero rotation, quarter turns, wrap points, extreme scale/pos
      pending_objects.push_back(make_object(16'h0000, 16'h0000, 16'h0000, 0, 32'h10000));
      pending_objects.push_back(make_object(16'hFFFF, 16'hFFFF, 16'hFFFF,
                                            32'h7FFFFFFF, 32'h7FFFFFFF));
      pending_objects.push_back(make_object(16'h8000, 16'h0000, 16'h0000,
                                            32'h80000000, 32'h80000000));
      pending_objects.push_back(make_object(16'h0000, 16'h8000, 16'h0000, 1, 32'h10000));
      pending_objects.push_back(make_object(16'h0000, 16'h0000, 16'h8000, -1, 32'hFFFF0000));
      pending_objects.push_back(make_object(16'h4000, 16'h4000, 16'h4000, 0, 32'h7FFFFFFF));
      pending_objects.push_back(make_object(16'hC000, 16'h2000, 16'h7FFF, 0, 32'h80000000));
      pending_objects.push_back(make_object(16'h7FFF, 16'h8001, 16'hC000, 32'h12345678, 0));
      pending_objects.push_back(make_object(16'h5555, 16'hAAAA, 16'h1234,
                                            32'hFFFFFFFF, 32'hFFFFFFFF));
      repeat (150) begin
         o.yaw = 16'($urandom());
         o.pitch = 16'($urandom());
         o.roll = 16'($urandom());
         for (int i = 0; i < 3; i++) begin
            o.pos[i] = rand_word();
            o.scl[i] = rand_word();
         end
         pending_objects.push_back(o);
      end
      stimulus_done = 1;
   end

   // driver: bursts with random gaps
   int burst_left = 0, gap_left = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (!req_valid || !req_stall) begin
            if (gap_left > 0 || pending_objects.size() == 0) begin
               req_valid <= 1'b0;
               if (gap_left > 0) gap_left <= gap_left - 1;
            end else begin
               object_type o;
               o = pending_objects.pop_front();
               predict_rows(o);
               req_valid <= 1'b1;
               req_yaw_angle <= o.yaw;
               req_pitch_angle <= o.pitch;
               req_roll_angle <= o.roll;
               req_pos_x <= o.pos[0]; req_pos_y <= o.pos[1]; req_pos_z <= o.pos[2];
               req_scale_x <= o.scl[0]; req_scale_y <= o.scl[1];
               req_scale_z <= o.scl[2];
               if (burst_left == 0) begin
                  burst_left <= $urandom_range(1, 12);
                  gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 8);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end
         end
      end
   end

   // receiver stall pattern, with one long hold-off
   int rx_count = 0;
   int hold_left = 0;
   bit hold_done = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
         end else if (!hold_done && rx_count >= 60) begin
            hold_done <= 1;
            hold_left <= 300;
            rsp_stall <= 1'b1;
         end else if (rx_count < 30 || (rx_count > 200 && rx_count < 260)) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(0, 3) == 0);
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      row_type e;
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (rsp_valid && !rsp_stall) begin
            rx_count <= rx_count + 1;
            if (expected_rows.size() == 0) begin
               $error("unexpected response row %0d", rsp_row_index);
               errors++;
            end else begin
               e = expected_rows.pop_front();
               if (rsp_row_index !== e.row) begin
                  $error("row_index expected %0d got %0d", e.row, rsp_row_index);
                  errors++;
               end
               if (rsp_col0 !== e.c0) begin
                  $error("col0 expected %0d got %0d", e.c0, rsp_col0);
                  errors++;
               end
               if (rsp_col1 !== e.c1) begin
                  $error("col1 expected %0d got %0d", e.c1, rsp_col1);
                  errors++;
               end
               if (rsp_col2 !== e.c2) begin
                  $error("col2 expected %0d got %0d", e.c2, rsp_col2);
                  errors++;
               end
               if (rsp_col3 !== e.c3) begin
                  $error("col3 expected %0d got %0d", e.c3, rsp_col3);
                  errors++;
               end
               if (rsp_last_row !== e.last) begin
                  $error("last_row expected %0d got %0d", e.last, rsp_last_row);
                  errors++;
               end
            end
         end
      end
   end

   initial begin
      wait (stimulus_done);
      while (!((pending_objects.size() == 0 && !(req_valid && req_stall)
                && expected_rows.size() == 0) || idle_cycles >= IDLE_LIMIT))
         @(posedge clock);
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb: failure");
      end else begin
         repeat (60) @(posedge clock);
         if (errors == 0 && expected_rows.size() == 0)
            $display("tb: success");
         else
            $display("tb: failure");
      end
      $finish;
   end

endmodule
